// File: rtl/grid_min_path_sum_unit_macros.svh
// assertion helpers included by grid_min_path_sum_unit.sv
`ifndef GRID_MIN_PATH_SUM_UNIT_MACROS_SVH
`define GRID_MIN_PATH_SUM_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define GMPS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define GMPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/gmps_pkg.sv
package gmps_pkg;

    // width of the result word
    localparam int PATH_W = 25;

    // width of the config data word
    localparam int DIM_W = 9;

    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NUM_ROWS = 2'd0,
        REG_NUM_COLS = 2'd1
    } cfg_reg_t;

endpackage

// File: rtl/grid_min_path_sum_unit.sv
// path_sum is registered, valid in the cycle after the top-left word is accepted
// throughput: one cell word per cycle while in_ready is high, set by the add/min
// loop via right_best and the row store, one cell per column, shifting each word
// reset: sizes go to 1x1, walk restarts at the bottom-right cell, output empty;
// the row store is not cleared, the bottom row of each grid fills it first
module grid_min_path_sum_unit #(
    parameter int MAX_COLS  = 256,
    parameter int MAX_ROWS  = 256,
    parameter int CELL_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [gmps_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [gmps_pkg::DIM_W-1:0]           cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [CELL_BITS-1:0]          cell_value,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [gmps_pkg::PATH_W-1:0]   path_sum
);

`include "grid_min_path_sum_unit_macros.svh"

    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    // a path touches at most rows + cols - 1 cells
    localparam int SUM_W = CELL_BITS + ROW_W + COL_W + 1;
    localparam int EXT_W = (SUM_W > gmps_pkg::PATH_W) ? SUM_W : gmps_pkg::PATH_W;

    logic [ROW_W-1:0] rows_m1_reg, rows_m1_next;
    logic [COL_W-1:0] cols_m1_reg, cols_m1_next;
    logic [ROW_W-1:0] row_index_reg, row_index_next;
    logic [COL_W-1:0] col_index_reg, col_index_next;
    logic signed [SUM_W-1:0] right_best_reg, right_best_next;
    logic out_valid_reg, out_valid_next;
    logic signed [gmps_pkg::PATH_W-1:0] path_sum_reg, path_sum_next;

    logic in_fire;
    logic last_row;
    logic last_col;
    logic last_cell;
    logic signed [SUM_W-1:0] cell_ext;
    logic signed [SUM_W-1:0] below;
    logic signed [SUM_W-1:0] best_in;
    logic signed [SUM_W-1:0] val;
    logic signed [EXT_W-1:0] val_ext;
    logic signed [SUM_W-1:0] chain_q [MAX_COLS];

    function automatic logic [ROW_W-1:0] rows_limit(input logic [gmps_pkg::DIM_W-1:0] v);
        int n;
        begin
            n = int'(v);
            if (n == 0)
            begin
                n = 1;
            end
            else if (n > MAX_ROWS)
            begin
                n = MAX_ROWS;
            end
            rows_limit = ROW_W'(n - 1);
        end
    endfunction

    function automatic logic [COL_W-1:0] cols_limit(input logic [gmps_pkg::DIM_W-1:0] v);
        int n;
        begin
            n = int'(v);
            if (n == 0)
            begin
                n = 1;
            end
            else if (n > MAX_COLS)
            begin
                n = MAX_COLS;
            end
            cols_limit = COL_W'(n - 1);
        end
    endfunction

    // output register frees itself in the same cycle it is drained
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign path_sum  = path_sum_reg;

    assign last_row  = (row_index_reg == rows_m1_reg);
    assign last_col  = (col_index_reg == cols_m1_reg);
    assign last_cell = (row_index_reg == '0) && (col_index_reg == '0);

    assign cell_ext = SUM_W'(cell_value);
    // head of the chain holds this column's value from the row below
    assign below    = chain_q[0];

    always_comb
    begin
        if (last_row && last_col)
        begin
            best_in = '0;
        end
        else if (last_row)
        begin
            best_in = right_best_reg;
        end
        else if (last_col)
        begin
            best_in = below;
        end
        else
        begin
            best_in = (below < right_best_reg) ? below : right_best_reg;
        end
    end

    assign val     = cell_ext + best_in;
    assign val_ext = EXT_W'(val);

    genvar k;
    generate
        for (k = 0; k < MAX_COLS; k++)
        begin : g_chain
            logic signed [SUM_W-1:0] from_right;
            if (k == MAX_COLS - 1)
            begin : g_end
                assign from_right = val;
            end
            else
            begin : g_mid
                assign from_right = chain_q[k+1];
            end
            gmps_cell #(
                .IDX   (k),
                .COL_W (COL_W),
                .SUM_W (SUM_W)
            ) u_cell (
                .clk        (clk),
                .shift      (in_fire),
                .cols_m1    (cols_m1_reg),
                .inject     (val),
                .from_right (from_right),
                .q          (chain_q[k])
            );
        end
    endgenerate

    always_comb
    begin
        rows_m1_next    = rows_m1_reg;
        cols_m1_next    = cols_m1_reg;
        row_index_next  = row_index_reg;
        col_index_next  = col_index_reg;
        right_best_next = right_best_reg;
        out_valid_next  = out_valid_reg;
        path_sum_next   = path_sum_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_we)
        begin
            case (cfg_index)
                gmps_pkg::REG_NUM_ROWS:
                begin
                    rows_m1_next   = rows_limit(cfg_data);
                    row_index_next = rows_limit(cfg_data);
                    col_index_next = cols_m1_reg;
                end
                gmps_pkg::REG_NUM_COLS:
                begin
                    cols_m1_next   = cols_limit(cfg_data);
                    col_index_next = cols_limit(cfg_data);
                    row_index_next = rows_m1_reg;
                end
                default:
                begin
                end
            endcase
        end
        else if (in_fire)
        begin
            right_best_next = val;
            if (col_index_reg != '0)
            begin
                col_index_next = col_index_reg - 1'b1;
            end
            else if (row_index_reg != '0)
            begin
                row_index_next = row_index_reg - 1'b1;
                col_index_next = cols_m1_reg;
            end
            else
            begin
                row_index_next = rows_m1_reg;
                col_index_next = cols_m1_reg;
                out_valid_next = 1'b1;
                path_sum_next  = val_ext[gmps_pkg::PATH_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_m1_reg    <= '0;
            cols_m1_reg    <= '0;
            row_index_reg  <= '0;
            col_index_reg  <= '0;
            right_best_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            rows_m1_reg    <= rows_m1_next;
            cols_m1_reg    <= cols_m1_next;
            row_index_reg  <= row_index_next;
            col_index_reg  <= col_index_next;
            right_best_reg <= right_best_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        path_sum_reg <= path_sum_next;
    end

    `GMPS_ASSERT_NOW(a_col_in_range, 1'b1, col_index_reg <= cols_m1_reg, "column index past row width")
    `GMPS_ASSERT_NOW(a_row_in_range, 1'b1, row_index_reg <= rows_m1_reg, "row index past grid height")
    `GMPS_ASSERT_NEXT(a_result_follows, in_fire && last_cell && !cfg_we, out_valid, "top-left word gave no result")
    `GMPS_ASSERT_NEXT(a_cfg_restart, cfg_we && (cfg_index == gmps_pkg::REG_NUM_ROWS || cfg_index == gmps_pkg::REG_NUM_COLS), (row_index_reg == rows_m1_reg) && (col_index_reg == cols_m1_reg), "walk not restarted")

endmodule

// File: rtl/gmps_cell.sv
module gmps_cell #(
    parameter int IDX   = 0,
    parameter int COL_W = 8,
    parameter int SUM_W = 33
) (
    input  logic                    clk,
    input  logic                    shift,
    input  logic [COL_W-1:0]        cols_m1,
    input  logic signed [SUM_W-1:0] inject,
    input  logic signed [SUM_W-1:0] from_right,
    output logic signed [SUM_W-1:0] q
);

    logic                    tail;
    logic signed [SUM_W-1:0] q_reg;
    logic signed [SUM_W-1:0] q_next;

    // the cell at the last column index (cols_m1) takes the fresh value, the rest pass along
    assign tail = (cols_m1 == COL_W'(IDX));

    always_comb
    begin
        q_next = q_reg;
        if (shift)
        begin
            q_next = tail ? inject : from_right;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

// File: sim/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CFG_IDX_W = gmps_pkg::CFG_IDX_W;
    localparam int DIM_W     = gmps_pkg::DIM_W;
    localparam int PATH_W    = gmps_pkg::PATH_W;

    localparam int MAX_DIM = 256;
    localparam int CELL_W  = 16;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd2;

    typedef enum logic {
        STEP_CELL,
        STEP_WRITE
    } step_kind_t;

    typedef struct {
        step_kind_t                 kind;
        logic [CFG_IDX_W-1:0]       reg_idx;
        logic [DIM_W-1:0]           reg_val;
        logic signed [CELL_W-1:0]   cell_word;
        bit                         typed;
        logic signed [PATH_W-1:0]   sum;
    } step_t;

    localparam int SCRIPT_LEN = 33;

    logic                       clk;
    logic                       rst_n       = 1'b0;
    logic                       cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index   = '0;
    logic [DIM_W-1:0]           cfg_data    = '0;
    logic                       in_valid    = 1'b0;
    logic                       in_ready;
    logic signed [CELL_W-1:0]   cell_value  = '0;
    logic                       out_valid;
    logic                       out_ready   = 1'b0;
    logic signed [PATH_W-1:0]   path_sum;

    // shadow of the unit
    logic [DIM_W-1:0]           rows_reg;
    logic [DIM_W-1:0]           cols_reg;
    longint                     best_below [MAX_DIM];
    int                         row_pos;
    int                         col_pos;
    longint                     right_cost;

    logic signed [PATH_W-1:0]   pending_sums [$];
    int                         fail_count  = 0;
    int                         cells_sent  = 0;
    bit                         calm        = 1'b0;
    bit                         hold_req    = 1'b0;

    step_t script [SCRIPT_LEN] = '{
        '{STEP_CELL,  gmps_pkg::REG_NUM_ROWS, 9'd0,   16'sh7fff,   1'b1, 25'sd32767},
        '{STEP_CELL,  gmps_pkg::REG_NUM_ROWS, 9'd0,   16'sh8000,   1'b1, -25'sd32768},
        '{STEP_CELL,  gmps_pkg::REG_NUM_ROWS, 9'd0,   16'sd0,      1'b1, 25'sd0},
        '{STEP_WRITE, gmps_pkg::REG_NUM_ROWS, 9'd0,   16'sd0,      1'b0, 25'sd0},
        '{STEP_WRITE, gmps_pkg::REG_NUM_COLS, 9'd0,   16'sd0,      1'b0, 25'sd0},
        '{STEP_CELL,  gmps_pkg::REG_NUM_ROWS, 9'd0,   -16'sd1,     1'b1, -25'sd1},
        '{STEP_WRITE, REG_UNUSED,             9'd5,   16'sd0,      1'b0, 25'sd0},
        '{STEP_CELL,  gmps_pkg::REG_NUM_ROWS, 9'd0,   16'sd1234,   1'b1, 25'sd1234},
        '{STEP_WRITE, gmps_pkg::REG_NUM_ROWS, 9'd2,   16'sd0,      1'b0, 25'sd0},
        '{STEP_WRITE, gmps_pkg::REG_NUM_COLS, 9'd2,   16'sd0,      1'b0, 25'sd0},
        '{STEP_CELL,  gmps_pkg::REG_NUM_ROWS, 9'd0,   16'sd1,      1'b0, 25'sd0},
        '{STEP_CELL,  gmps_pkg::REG_NUM_ROWS, 9'd0,   16'sd2,      1'b0, 25'sd0},
        '{STEP_CELL,  gmps_pkg::REG_NUM_ROWS, 9'd0,   16'sd3,      1'b0, 25'sd0},
        '{STEP_CELL,  gmps_pkg::REG_NUM_ROWS, 9'd0,   16'sd4,      1'b0, 25'sd0},
        // half a grid, then dropped by the next write
        '{STEP_CELL,  gmps_pkg::REG_NUM_ROWS, 9'd0,   16'sd5,      1'b0, 25'sd0},
        '{STEP_CELL,  gmps_pkg::REG_NUM_ROWS, 9'd0,   16'sd6,      1'b0, 25'sd0},
        '{STEP_WRITE, gmps_pkg::REG_NUM_COLS, 9'd3,   16'sd0,      1'b0, 25'sd0},
        '{STEP_CELL,  gmps_pkg::REG_NUM_ROWS, 9'd0,   16'sh7fff,   1'b0, 25'sd0},
        '{STEP_CELL,  gmps_pkg::REG_NUM_ROWS, 9'd0,   16'sh8000,   1'b0, 25'sd0},
        '{STEP_CELL,  gmps_pkg::REG_NUM_ROWS, 9'd0,   16'sd100,    1'b0, 25'sd0},
        '{STEP_CELL,  gmps_pkg::REG_NUM_ROWS, 9'd0,   -16'sd100,   1'b0, 25'sd0},
        '{STEP_CELL,  gmps_pkg::REG_NUM_ROWS, 9'd0,   16'sd7,      1'b0, 25'sd0},
        '{STEP_CELL,  gmps_pkg::REG_NUM_ROWS, 9'd0,   16'sd0,      1'b0, 25'sd0},
        '{STEP_WRITE, gmps_pkg::REG_NUM_ROWS, 9'd3,   16'sd0,      1'b0, 25'sd0},
        '{STEP_WRITE, gmps_pkg::REG_NUM_COLS, 9'd1,   16'sd0,      1'b0, 25'sd0},
        '{STEP_CELL,  gmps_pkg::REG_NUM_ROWS, 9'd0,   16'sd10,     1'b0, 25'sd0},
        '{STEP_CELL,  gmps_pkg::REG_NUM_ROWS, 9'd0,   16'sd20,     1'b0, 25'sd0},
        '{STEP_CELL,  gmps_pkg::REG_NUM_ROWS, 9'd0,   16'sd30,     1'b0, 25'sd0},
        '{STEP_WRITE, gmps_pkg::REG_NUM_ROWS, 9'd1,   16'sd0,      1'b0, 25'sd0},
        '{STEP_WRITE, gmps_pkg::REG_NUM_COLS, 9'd3,   16'sd0,      1'b0, 25'sd0},
        '{STEP_CELL,  gmps_pkg::REG_NUM_ROWS, 9'd0,   -16'sd5,     1'b0, 25'sd0},
        '{STEP_CELL,  gmps_pkg::REG_NUM_ROWS, 9'd0,   -16'sd6,     1'b0, 25'sd0},
        '{STEP_CELL,  gmps_pkg::REG_NUM_ROWS, 9'd0,   -16'sd7,     1'b0, 25'sd0}
    };

    grid_min_path_sum_unit u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cell_value (cell_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .path_sum   (path_sum)
    );

    function automatic int dims_used(input logic [DIM_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > MAX_DIM)
            return MAX_DIM;
        return int'(v);
    endfunction

    function automatic void restart_walk();
        row_pos = dims_used(rows_reg) - 1;
        col_pos = dims_used(cols_reg) - 1;
    endfunction

    function automatic void reset_shadow();
        rows_reg   = 1;
        cols_reg   = 1;
        right_cost = 0;
        foreach (best_below[i])
            best_below[i] = 0;
        restart_walk();
    endfunction

    // one cell of the bottom-up walk; returns 1 when the top-left cell closes the grid
    function automatic bit walk_cell(input logic signed [CELL_W-1:0] cell_word,
                                     output logic signed [PATH_W-1:0] sum);
        int     rows;
        int     cols;
        int     r;
        int     c;
        longint cost;
        bit     bottom;
        bit     right;
        rows = dims_used(rows_reg);
        cols = dims_used(cols_reg);
        r = row_pos;
        c = col_pos;
        if (r >= rows)
            r = rows - 1;
        if (c >= cols)
            c = cols - 1;
        bottom = (r == rows - 1);
        right  = (c == cols - 1);
        if (bottom && right)
            cost = cell_word;
        else if (bottom)
            cost = cell_word + right_cost;
        else if (right)
            cost = cell_word + best_below[c];
        else
            cost = cell_word + (best_below[c] < right_cost ? best_below[c] : right_cost);
        best_below[c] = cost;
        right_cost = cost;
        sum = cost[PATH_W-1:0];
        if (c != 0)
        begin
            row_pos = r;
            col_pos = c - 1;
            return 1'b0;
        end
        if (r != 0)
        begin
            row_pos = r - 1;
            col_pos = cols - 1;
            return 1'b0;
        end
        restart_walk();
        return 1'b1;
    endfunction

    function automatic logic [CELL_W-1:0] pick_cell();
        case ($urandom_range(7))
            0: return 16'h7fff;
            1: return 16'h8000;
            default: return CELL_W'($urandom);
        endcase
    endfunction

    task automatic push_cell(input logic signed [CELL_W-1:0] v,
                             input bit typed = 1'b0,
                             input logic signed [PATH_W-1:0] typed_sum = '0);
        logic signed [PATH_W-1:0] sum;
        if (!calm)
            while ($urandom_range(99) < 14)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        in_valid   <= 1'b1;
        cell_value <= v;
        do
            @(posedge clk);
        while (!in_ready);
        cells_sent++;
        if (walk_cell(v, sum))
        begin
            pending_sums.push_back(typed ? typed_sum : sum);
        end
    endtask

    // only written with the unit drained; a dropped partial grid emits nothing
    task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
        in_valid <= 1'b0;
        while (pending_sums.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == gmps_pkg::REG_NUM_ROWS)
            rows_reg = val;
        else if (idx == gmps_pkg::REG_NUM_COLS)
            cols_reg = val;
        else
            return;
        restart_walk();
    endtask

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("grid_min_path_sum_unit: mismatch");
        $finish;
    end

    // receiver side of the result word
    initial
    begin
        int n;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                for (n = 0; n < 400; n++)
                    @(posedge clk);
            end
            else
                out_ready <= calm || ($urandom_range(99) >= 14);
        end
    end

    always @(posedge clk)
    begin
        logic signed [PATH_W-1:0] want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_sums.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected path_sum word %0d", path_sum);
            end
            else
            begin
                want = pending_sums.pop_front();
                if (path_sum !== want)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("path_sum expected %0d got %0d", want, path_sum);
                end
            end
        end
    end

    initial
    begin
        int               total;
        int               n_grids;
        int               part;
        logic [DIM_W-1:0] r_raw;
        logic [DIM_W-1:0] c_raw;
        reset_shadow();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
        begin
            if (script[i].kind == STEP_WRITE)
                reg_write(script[i].reg_idx, script[i].reg_val);
            else
                push_cell(script[i].cell_word, script[i].typed, script[i].sum);
        end

        // 1x1 grids while the result side stays blocked, so the input backs up
        reg_write(gmps_pkg::REG_NUM_ROWS, 9'd1);
        reg_write(gmps_pkg::REG_NUM_COLS, 9'd1);
        hold_req = 1'b1;
        repeat (40) push_cell(pick_cell());

        while (cells_sent < 480)
        begin
            calm = (cells_sent >= 300);
            case ($urandom_range(9))
                0:
                begin
                    r_raw = DIM_W'($urandom_range(1, MAX_DIM));
                    c_raw = DIM_W'($urandom_range(1, 2));
                end
                1:
                begin
                    r_raw = DIM_W'($urandom_range(1, 2));
                    c_raw = DIM_W'($urandom_range(1, MAX_DIM));
                end
                2:
                begin
                    // out-of-range sizes clamp to one or to the maximum
                    r_raw = $urandom_range(1) ? DIM_W'(0) : DIM_W'($urandom_range(257, 511));
                    c_raw = $urandom_range(1) ? DIM_W'(0) : DIM_W'($urandom_range(1, 2));
                end
                default:
                begin
                    r_raw = DIM_W'($urandom_range(1, 6));
                    c_raw = DIM_W'($urandom_range(1, 6));
                end
            endcase
            if ($urandom_range(1))
            begin
                reg_write(gmps_pkg::REG_NUM_ROWS, r_raw);
                reg_write(gmps_pkg::REG_NUM_COLS, c_raw);
            end
            else
            begin
                reg_write(gmps_pkg::REG_NUM_COLS, c_raw);
                reg_write(gmps_pkg::REG_NUM_ROWS, r_raw);
            end
            total = dims_used(r_raw) * dims_used(c_raw);
            n_grids = (total > 64) ? 1 : $urandom_range(1, 4);
            repeat (n_grids * total) push_cell(pick_cell());
            if ($urandom_range(9) == 0 && total > 1)
            begin
                part = $urandom_range(1, total - 1);
                repeat (part) push_cell(pick_cell());
            end
        end
        calm = 1'b0;

        // longest single-line grids of all-max and all-min cells
        reg_write(gmps_pkg::REG_NUM_ROWS, 9'd511);
        reg_write(gmps_pkg::REG_NUM_COLS, 9'd1);
        repeat (MAX_DIM) push_cell(16'sh7fff, 1'b1, 25'sd8388352);
        reg_write(gmps_pkg::REG_NUM_ROWS, 9'd0);
        reg_write(gmps_pkg::REG_NUM_COLS, 9'd300);
        repeat (MAX_DIM) push_cell(16'sh8000, 1'b1, -25'sd8388608);

        in_valid <= 1'b0;
        while (pending_sums.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("grid_min_path_sum_unit: match");
        else
            $display("grid_min_path_sum_unit: mismatch");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/gmps_pkg.sv
rtl/gmps_cell.sv
rtl/grid_min_path_sum_unit.sv
sim/testbench.sv
